### src/shared_counter_barrier_server_unit_defines.svh
// Assertion macros for the shared counter barrier server.
// Uses the clk and rst_n names of the including module; empty under SYNTHESIS.
`ifndef SHARED_COUNTER_BARRIER_SERVER_UNIT_DEFINES_SVH
`define SHARED_COUNTER_BARRIER_SERVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scbs: same-cycle check failed");
// next-cycle implication
`define SCBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scbs: next-cycle check failed");
`else
`define SCBS_ASSERT_SAME(label, ante, cons)
`define SCBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/scbs_pkg.sv
// Shared types and constants for the shared counter barrier server.
// No dependencies.
`default_nettype none

package scbs_pkg;

  localparam int DEF_MAX_NODES     = 64;
  localparam int DEF_COUNTER_WIDTH = 32;

  // classified request kinds
  typedef enum logic [1:0] {
    OP_FETCH,
    OP_LOOP,
    OP_TERM
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  src;
    logic [6:0]  group;
    logic [15:0] incr;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic releasing;
  } back_stat_t;

endpackage

`default_nettype wire

### src/shared_counter_barrier_server_unit.sv
// Top level of the shared counter barrier server: front end, command queue, back end.
// Depends on scbs_pkg, scbs_front, scbs_cmd_fifo, scbs_back and the defines header.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid / in_stall  action, source_node, group_size, increment
//   out_      reply      out_valid / out_stall dest_node, counter_value, last, finished
//   cfg_      register   cfg_wr_en            cfg_wr_data (node_count)
//
// Fetch and loop-done requests without release are served from the idle state, so the block
// sustains one such request per cycle unless a fetch waits on a stalled output register.
// The queue holds two entries. A loop release reads each waiter from memory, then loads it
// into the output register; a termination release sends one reply per cycle. Output register
// stalls hold the back end. Reset is synchronous; the waiter list needs no clearing, and
// node_count comes up as 64.
`default_nettype none
`include "shared_counter_barrier_server_unit_defines.svh"

module shared_counter_barrier_server_unit #(
  parameter int MAX_NODES     = scbs_pkg::DEF_MAX_NODES,
  parameter int COUNTER_WIDTH = scbs_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [5:0]  in_source_node,
  input  wire logic [6:0]  in_group_size,
  input  wire logic [15:0] in_increment,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_dest_node,
  output logic [31:0]      out_counter_value,
  output logic             out_last,
  output logic             out_finished
);
  import scbs_pkg::*;

  logic       q_ready, q_push, cmd_valid, cmd_pop;
  cmd_t       q_cmd, cmd;
  back_stat_t stat;

  scbs_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_source_node (in_source_node),
    .in_group_size  (in_group_size),
    .in_increment   (in_increment),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  scbs_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .ready     (q_ready),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (cmd_pop)
  );

  scbs_back #(
    .MAX_NODES     (MAX_NODES),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_dest_node     (out_dest_node),
    .out_counter_value (out_counter_value),
    .out_last          (out_last),
    .out_finished      (out_finished),
    .stat              (stat)
  );

  // nothing more goes out after the final termination reply
  `SCBS_ASSERT_NEXT(a_quiet_after_finish, out_valid && !out_stall && out_finished && out_last, !out_valid)
  // once halted, only termination replies can still be waiting
  `SCBS_ASSERT_SAME(a_halted_reply_finished, stat.halted && out_valid, out_finished)
  // halting coincides with loading the last termination reply
  `SCBS_ASSERT_SAME(a_halt_on_last, $rose(stat.halted), out_valid && out_last && out_finished)
  // the queue is left alone during a release burst
  `SCBS_ASSERT_SAME(a_no_pop_in_burst, stat.releasing, !cmd_pop)

endmodule

`default_nettype wire

### src/scbs_front.sv
// Front end: takes request transfers and classifies them into queue commands.
// Depends on scbs_pkg.
`default_nettype none

module scbs_front (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [5:0]  in_source_node,
  input  wire logic [6:0]  in_group_size,
  input  wire logic [15:0] in_increment,
  input  wire logic        q_ready,
  output logic             q_push,
  output scbs_pkg::cmd_t   q_cmd
);
  import scbs_pkg::*;

  localparam logic [1:0] ACT_FETCH = 2'd0;
  localparam logic [1:0] ACT_LOOP  = 2'd1;
  localparam logic [1:0] ACT_TERM  = 2'd2;

  logic known;

  assign in_stall = !q_ready;

  always_comb begin
    known    = 1'b1;
    q_cmd.op = OP_FETCH;
    unique case (in_action)
      ACT_FETCH: q_cmd.op = OP_FETCH;
      ACT_LOOP:  q_cmd.op = OP_LOOP;
      ACT_TERM:  q_cmd.op = OP_TERM;
      default:   known = 1'b0;   // unused code: swallowed here
    endcase
    q_cmd.src   = in_source_node;
    q_cmd.group = in_group_size;
    q_cmd.incr  = in_increment;
  end

  assign q_push = in_valid && q_ready && known;

endmodule

`default_nettype wire

### src/scbs_cmd_fifo.sv
// Short command queue between front end and back end.
// Depends on scbs_pkg.
`default_nettype none

module scbs_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire scbs_pkg::cmd_t push_cmd,
  output logic                ready,
  output logic                cmd_valid,
  output scbs_pkg::cmd_t      cmd,
  input  wire logic           pop
);
  import scbs_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign ready     = (count_r != CNT_W'(DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = slot_r[rd_ptr_r];
  assign do_push   = push && ready;
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### src/scbs_back.sv
// Back end: counter, waiter list memory, termination count and reply sequencer.
// Depends on scbs_pkg.
`default_nettype none

module scbs_back #(
  parameter int MAX_NODES     = scbs_pkg::DEF_MAX_NODES,
  parameter int COUNTER_WIDTH = scbs_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [6:0]     cfg_wr_data,
  input  wire logic           cmd_valid,
  input  wire scbs_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [5:0]          out_dest_node,
  output logic [31:0]         out_counter_value,
  output logic                out_last,
  output logic                out_finished,
  output scbs_pkg::back_stat_t stat
);
  import scbs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int WCNT_W = $clog2(MAX_NODES + 1);
  localparam int WCMP_W = (WCNT_W > 7) ? WCNT_W : 7;
  localparam int NW     = (WCNT_W > 7) ? WCNT_W : 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LREAD,
    ST_LEMIT,
    ST_TEMIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [COUNTER_WIDTH-1:0] counter_r, counter_nxt;
  logic [WCNT_W-1:0]        waiter_count_r, waiter_count_nxt;
  logic [6:0]               term_count_r, term_count_nxt;
  logic                     halted_r, halted_nxt;
  logic [6:0]               node_count_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [5:0]               out_dest_r, out_dest_nxt;
  logic [31:0]              out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_fin_r, out_fin_nxt;

  logic [5:0]               waiter_mem [MAX_NODES];
  logic [5:0]               rd_data_r;
  logic                     mem_we;

  logic                     out_free;
  logic [COUNTER_WIDTH+31:0] cnt_ext;
  logic [31:0]              reply_value;
  logic [COUNTER_WIDTH+15:0] fetch_sum;
  logic [WCNT_W-1:0]        wcnt_inc;
  logic                     list_full, group_hit;
  logic [6:0]               term_inc;
  logic [NW-1:0]            nc_w, nodes;
  logic                     term_release, term_last;
  logic [IDX_W+5:0]         idx_ext;

  assign out_free    = !out_valid_r || !out_stall;
  assign cnt_ext     = {32'd0, counter_r};
  assign reply_value = cnt_ext[31:0];
  assign fetch_sum   = {16'd0, counter_r} + {{COUNTER_WIDTH{1'b0}}, cmd.incr};
  assign wcnt_inc    = waiter_count_r + WCNT_W'(1);
  assign list_full   = (waiter_count_r >= WCNT_W'(MAX_NODES));
  assign group_hit   = (WCMP_W'(wcnt_inc) == WCMP_W'(cmd.group));
  assign term_inc    = (term_count_r != 7'h7F) ? term_count_r + 7'd1 : term_count_r;
  assign idx_ext     = {6'd0, idx_r};

  // node count clamped to 1..MAX_NODES
  assign nc_w  = NW'(node_count_r);
  assign nodes = (nc_w == '0) ? NW'(1) :
                 (nc_w > NW'(MAX_NODES)) ? NW'(MAX_NODES) : nc_w;
  assign term_release = (NW'(term_inc) >= nodes);
  assign term_last    = (NW'(idx_r) == nodes - NW'(1));

  always_comb begin
    state_nxt        = state_r;
    counter_nxt      = counter_r;
    waiter_count_nxt = waiter_count_r;
    term_count_nxt   = term_count_r;
    halted_nxt       = halted_r;
    idx_nxt          = idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_dest_nxt     = out_dest_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    out_fin_nxt      = out_fin_r;
    cmd_pop          = 1'b0;
    mem_we           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (halted_r) begin
            cmd_pop = 1'b1;
          end else begin
            unique case (cmd.op)
              OP_FETCH: begin
                if (out_free) begin
                  cmd_pop       = 1'b1;
                  out_valid_nxt = 1'b1;
                  out_dest_nxt  = cmd.src;
                  out_value_nxt = reply_value;
                  out_last_nxt  = 1'b1;
                  out_fin_nxt   = 1'b0;
                  counter_nxt   = fetch_sum[COUNTER_WIDTH-1:0];
                end
              end
              OP_LOOP: begin
                cmd_pop = 1'b1;
                if (!list_full) begin
                  mem_we           = 1'b1;
                  waiter_count_nxt = wcnt_inc;
                  if (group_hit) begin
                    // newest entry is the one written now
                    idx_nxt   = waiter_count_r[IDX_W-1:0];
                    state_nxt = ST_LREAD;
                  end
                end
              end
              OP_TERM: begin
                cmd_pop        = 1'b1;
                term_count_nxt = term_inc;
                if (term_release) begin
                  idx_nxt   = '0;
                  state_nxt = ST_TEMIT;
                end
              end
              default: cmd_pop = 1'b1;
            endcase
          end
        end
      end
      ST_LREAD: state_nxt = ST_LEMIT;
      ST_LEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dest_nxt  = rd_data_r;
          out_value_nxt = reply_value;
          out_last_nxt  = (idx_r == '0);
          out_fin_nxt   = 1'b0;
          if (idx_r == '0) begin
            counter_nxt      = '0;
            waiter_count_nxt = '0;
            state_nxt        = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_LREAD;
          end
        end
      end
      ST_TEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dest_nxt  = idx_ext[5:0];
          out_value_nxt = reply_value;
          out_last_nxt  = term_last;
          out_fin_nxt   = 1'b1;
          if (term_last) begin
            halted_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      counter_r      <= '0;
      waiter_count_r <= '0;
      term_count_r   <= '0;
      halted_r       <= 1'b0;
      node_count_r   <= 7'd64;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      counter_r      <= counter_nxt;
      waiter_count_r <= waiter_count_nxt;
      term_count_r   <= term_count_nxt;
      halted_r       <= halted_nxt;
      idx_r          <= idx_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
    out_dest_r  <= out_dest_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  // waiter list: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      waiter_mem[waiter_count_r[IDX_W-1:0]] <= cmd.src;
    end
    if (state_r == ST_LREAD) begin
      rd_data_r <= waiter_mem[idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_node     = out_dest_r;
  assign out_counter_value = out_value_r;
  assign out_last          = out_last_r;
  assign out_finished      = out_fin_r;
  assign stat.halted       = halted_r;
  assign stat.releasing    = (state_r != ST_IDLE);

endmodule

`default_nettype wire

### sim/scbs_reply_checker.sv
// Reply checker for the shared counter barrier server: tracks the counter, waiter list and
// termination state from the request and register ports, and checks every reply transfer.
// Depends on scbs_pkg.
module scbs_reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_source_node,
  input  logic [6:0]  in_group_size,
  input  logic [15:0] in_increment,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_dest_node,
  input  logic [31:0] out_counter_value,
  input  logic        out_last,
  input  logic        out_finished,
  output int          errors,
  output int          outstanding
);
  import scbs_pkg::*;

  localparam int NODES = DEF_MAX_NODES;

  typedef struct {
    logic [5:0]  dest;
    logic [31:0] value;
    logic        last;
    logic        fin;
  } reply_t;

  reply_t      replies_due[$];
  logic [6:0]  node_cfg;
  logic [31:0] work_count;
  int          waiting;
  logic [5:0]  waiter_ids [NODES];
  logic [6:0]  terminations;
  logic        halted;

  function automatic void queue_reply(input logic [5:0] dest, input logic [31:0] value,
                                      input logic last, input logic fin);
    reply_t r;
    r.dest  = dest;
    r.value = value;
    r.last  = last;
    r.fin   = fin;
    replies_due.push_back(r);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int     nodes;
    if (!rst_n) begin
      node_cfg     = 7'd64;
      work_count   = '0;
      waiting      = 0;
      terminations = '0;
      halted       = 1'b0;
      replies_due.delete();
    end else begin
      if (cfg_wr_en)
        node_cfg = cfg_wr_data;

      // request transfer: work out the replies it causes
      if (in_valid && !in_stall && !halted) begin
        case (in_action)
          OP_FETCH: begin
            queue_reply(in_source_node, work_count, 1'b1, 1'b0);
            work_count = work_count + 32'(in_increment);
          end
          OP_LOOP: begin
            if (waiting < NODES) begin
              waiter_ids[waiting] = in_source_node;
              waiting++;
              if (waiting == int'(in_group_size)) begin
                // release, newest waiter first
                while (waiting > 0) begin
                  waiting--;
                  queue_reply(waiter_ids[waiting], work_count, waiting == 0, 1'b0);
                end
                work_count = '0;
              end
            end
          end
          OP_TERM: begin
            nodes = int'(node_cfg);
            if (nodes < 1)
              nodes = 1;
            if (nodes > NODES)
              nodes = NODES;
            if (terminations != 7'h7F)
              terminations++;
            if (int'(terminations) >= nodes) begin
              for (int n = 0; n < nodes; n++)
                queue_reply(6'(n), work_count, n == nodes - 1, 1'b1);
              halted = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply dest %0d value %0d last %0b finished %0b",
                   $time, out_dest_node, out_counter_value, out_last, out_finished);
        end else begin
          want = replies_due.pop_front();
          if (out_dest_node !== want.dest) begin
            errors++;
            $display("%0t: dest_node expected %0d, got %0d", $time, want.dest,
                     out_dest_node);
          end
          if (out_counter_value !== want.value) begin
            errors++;
            $display("%0t: counter_value expected %0d, got %0d", $time, want.value,
                     out_counter_value);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b, got %0b", $time, want.last, out_last);
          end
          if (out_finished !== want.fin) begin
            errors++;
            $display("%0t: finished expected %0b, got %0b", $time, want.fin, out_finished);
          end
        end
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

### sim/testbench.sv
// Top of the shared counter barrier server test: clock, reset, request stimulus, reply stall
// and register writes; verdict from the error and outstanding counts of scbs_reply_checker.
// Depends on scbs_pkg, shared_counter_barrier_server_unit and scbs_reply_checker.
module testbench;
  import scbs_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 12;
  localparam int         SETTLE      = 16;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 2000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic [1:0]  in_action   = '0;
  logic [5:0]  in_source_node = '0;
  logic [6:0]  in_group_size  = '0;
  logic [15:0] in_increment   = '0;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [5:0]  out_dest_node;
  logic [31:0] out_counter_value;
  logic        out_last;
  logic        out_finished;

  int   errors;
  int   outstanding;
  logic calm       = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shared_counter_barrier_server_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_source_node    (in_source_node),
    .in_group_size     (in_group_size),
    .in_increment      (in_increment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_dest_node     (out_dest_node),
    .out_counter_value (out_counter_value),
    .out_last          (out_last),
    .out_finished      (out_finished)
  );

  scbs_reply_checker reply_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_source_node    (in_source_node),
    .in_group_size     (in_group_size),
    .in_increment      (in_increment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_dest_node     (out_dest_node),
    .out_counter_value (out_counter_value),
    .out_last          (out_last),
    .out_finished      (out_finished),
    .errors            (errors),
    .outstanding       (outstanding)
  );

  // reply side: random stalls, one long hold-off so the request side backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  // one request transfer, with an occasional gap before it
  task automatic offer(input logic [1:0] act, input logic [5:0] src, input logic [6:0] grp,
                       input logic [15:0] inc);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 16)
      gap = $urandom_range(3, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_source_node <= src;
    in_group_size  <= grp;
    in_increment   <= inc;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // wait until every reply is in, then let requests without replies clear the pipe
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [6:0]  plan [PHASES];
    logic [6:0]  grp;
    logic [5:0]  src;
    logic [15:0] inc;
    int          waiters;
    int          terms;
    int          node_lim;
    int          target;
    int          roll;
    int          idx;

    plan[0] = 7'd1;
    plan[1] = 7'd127;
    plan[2] = 7'd0;
    plan[3] = 7'($urandom_range(63, 33));
    plan[4] = 7'd64;
    plan[5] = 7'd100;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, unused code, barrier corner cases, one termination
    offer(OP_FETCH, 6'd0, 7'd0, 16'h0000);
    offer(OP_FETCH, 6'd63, 7'd127, 16'hFFFF);
    offer(OP_FETCH, 6'd42, 7'd64, 16'h0001);
    offer(ACT_UNUSED, 6'd63, 7'd127, 16'hFFFF);
    offer(OP_LOOP, 6'd5, 7'd1, 16'h0000);       // releases at once
    offer(OP_FETCH, 6'd1, 7'd1, 16'h1234);
    offer(OP_LOOP, 6'd10, 7'd3, 16'hFFFF);
    offer(OP_LOOP, 6'd20, 7'd3, 16'h0000);
    offer(OP_LOOP, 6'd30, 7'd3, 16'h5555);
    offer(OP_LOOP, 6'd7, 7'd127, 16'h0000);     // group never reachable, just waits
    offer(OP_LOOP, 6'd8, 7'd2, 16'h0000);
    offer(OP_LOOP, 6'd9, 7'd0, 16'h0000);
    offer(OP_LOOP, 6'd11, 7'd1, 16'h0000);      // group below the count
    offer(OP_LOOP, 6'd12, 7'd3, 16'h0000);
    offer(OP_TERM, 6'd3, 7'd0, 16'h0000);
    offer(OP_FETCH, 6'd42, 7'd85, 16'h5555);
    offer(OP_FETCH, 6'd21, 7'd42, 16'hAAAA);
    waiters  = 0;
    terms    = 1;
    node_lim = 64;
    target   = 64;
    idx      = 0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= plan[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      node_lim = (plan[p] == 0) ? 1 : ((plan[p] > 64) ? 64 : int'(plan[p]));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm <= (idx >= 36 && idx < 60);
        if (idx == 20)
          hold_req <= 1'b1;
        roll = $urandom_range(99);
        src  = 6'($urandom_range(63));
        if (roll < 5) begin
          offer(ACT_UNUSED, src, 7'($urandom_range(127)), 16'($urandom_range(16'hFFFF)));
        end else if (roll < 10 && terms + 1 < node_lim) begin
          offer(OP_TERM, src, 7'($urandom_range(127)), 16'($urandom_range(16'hFFFF)));
          terms++;
        end else if (roll < 55) begin
          // mostly well-formed barrier rounds, some waiters carry a stray group size
          if (waiters + 1 == target || $urandom_range(3) != 0) begin
            grp = 7'(target);
          end else begin
            do
              grp = 7'($urandom_range(127));
            while (int'(grp) == waiters + 1);
          end
          offer(OP_LOOP, src, grp, 16'($urandom_range(16'hFFFF)));
          waiters++;
          if (waiters == target) begin
            waiters = 0;
            target  = ($urandom_range(11) == 0) ? 64 : $urandom_range(6, 1);
          end
        end else begin
          case ($urandom_range(3))
            0:       inc = 16'h0000;
            1:       inc = 16'hFFFF;
            default: inc = 16'($urandom_range(16'hFFFF));
          endcase
          offer(OP_FETCH, src, 7'($urandom_range(127)), inc);
        end
        idx++;
      end
    end

    // fill the waiter list, then push two more that must be dropped
    while (waiters < 64 + 2) begin
      offer(OP_LOOP, 6'($urandom_range(63)), 7'd0, 16'($urandom_range(16'hFFFF)));
      waiters++;
    end
    // terminations up to the full group: final release, then the block goes quiet
    while (terms < node_lim) begin
      offer(OP_TERM, 6'($urandom_range(63)), 7'($urandom_range(127)),
            16'($urandom_range(16'hFFFF)));
      terms++;
    end
    offer(OP_FETCH, 6'd63, 7'd1, 16'hFFFF);
    offer(OP_LOOP, 6'd0, 7'd1, 16'h0000);
    offer(OP_TERM, 6'd5, 7'd1, 16'h0000);
    drain();

    if (errors == 0 && outstanding == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
